>>> rtl/core/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// shared types, codes and the size class lookup of the slab allocator
// ----------------------------------------------------------------------------
package scsa_pkg;

	localparam int CLASS_COUNT = 8;
	localparam int CLASS_W     = 3;
	localparam int SIZE_W      = 11;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_NO_PAGE   = 2'd2;

	localparam logic [15:0] CLASS_LIMIT [CLASS_COUNT] = '{
		16'd8, 16'd16, 16'd32, 16'd64, 16'd128, 16'd256, 16'd512, 16'd1024
	};

	typedef struct packed {
		logic        req_type;
		logic [15:0] size;
		logic [1:0]  alloc_type;
		logic [2:0]  free_class;
		logic [1:0]  free_page;
		logic [7:0]  free_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  size_class;
		logic [1:0]  page_index;
		logic [7:0]  slot_index;
		logic [31:0] type_bytes;
		logic [31:0] type_count;
	} resp_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LATCH,
		OP_DECODE,
		OP_POP,
		OP_ALLOC_DONE,
		OP_FREE_DONE,
		OP_REJECT_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic reject;
	} dp_status_t;

	// bit 3 set means above the largest class
	function automatic logic [3:0] class_of(input logic [15:0] sz);
		logic [3:0] c;
		c = 4'd8;
		for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
			if (sz <= CLASS_LIMIT[i]) begin
				c = 4'(i);
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/core/size_class_slab_allocator.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// slab allocator with eight power-of-two size classes
// ----------------------------------------------------------------------------
// one request beat at a time: an allocation passes the decode, pop and write
// states before it loads the result register, a free the decode and free write
// states, and a rejected request the decode and reject states; a write waits
// while the output register holds a stalled result. the sequence is set by the
// dependent accesses to the page counters and the registered reads of the slot
// stack and slot record memories. the request side stalls while a beat is in
// work; a finished result waits in its output register and the next request
// is accepted meanwhile. no clearing pass is needed after reset: fresh pages
// read their free stack from a low-water mark instead of a filled memory.
module size_class_slab_allocator #(
	parameter int PAGES_PER_CLASS    = 4,
	parameter int CATEGORY_COUNT     = 4,
	parameter int MAX_SLOTS_PER_PAGE = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  scsa_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output scsa_pkg::resp_t rsp
);
	import scsa_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t    cmd;
	dp_status_t sts;

	scsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// page state, open lists, slot memories and totals
	scsa_dp #(
		.PAGES_PER_CLASS    (PAGES_PER_CLASS),
		.CATEGORY_COUNT     (CATEGORY_COUNT),
		.MAX_SLOTS_PER_PAGE (MAX_SLOTS_PER_PAGE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

>>> rtl/core/scsa_dp.sv
// ----------------------------------------------------------------------------
// scsa_dp
// page tables, open lists, slot memories and category totals
// ----------------------------------------------------------------------------
module scsa_dp #(
	parameter int PAGES_PER_CLASS    = 4,
	parameter int CATEGORY_COUNT     = 4,
	parameter int MAX_SLOTS_PER_PAGE = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scsa_pkg::req_t       req,
	input  scsa_pkg::dp_cmd_t    cmd,
	output scsa_pkg::dp_status_t sts,
	output scsa_pkg::resp_t      rsp
);
	import scsa_pkg::*;

	localparam int PW         = (PAGES_PER_CLASS > 1) ? $clog2(PAGES_PER_CLASS) : 1;
	localparam int SW         = $clog2(MAX_SLOTS_PER_PAGE);
	localparam int CNT_W      = SW + 1;
	localparam int GW         = CLASS_W + PW;
	localparam int PAGE_SLOTS = 1 << GW;
	localparam int AW         = GW + SW;
	localparam int SLOT_TOTAL = 1 << AW;
	localparam int CW         = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS_PER_PAGE);

	typedef struct packed {
		logic          valid;
		logic [PW-1:0] idx;
	} link_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [1:0]        cat;
	} info_t;

	req_t               req_q;
	logic               active_q [PAGE_SLOTS];
	logic [CNT_W-1:0]   cnt_q    [PAGE_SLOTS];
	logic [CNT_W-1:0]   low_q    [PAGE_SLOTS];
	link_t              next_q   [PAGE_SLOTS];
	link_t              prev_q   [PAGE_SLOTS];
	link_t              head_q   [CLASS_COUNT];
	logic [31:0]        bytes_q  [CATEGORY_COUNT];
	logic [31:0]        count_q  [CATEGORY_COUNT];
	logic [SW-1:0]      stack_mem [SLOT_TOTAL];
	info_t              info_mem  [SLOT_TOTAL];

	logic [CLASS_W-1:0] cls_q;
	logic [PW-1:0]      page_q;
	logic [SW-1:0]      slot_q;
	logic [CW-1:0]      cat_q;
	logic [CNT_W-1:0]   c_q;
	logic               ident_q;
	logic [SW-1:0]      stack_rd_q;
	info_t              info_rd_q;
	resp_t              res_q;
	resp_t              rsp_q;

	// decode
	logic               is_free;
	logic [3:0]         cls_a;
	logic               too_large;
	logic [4:0]         at_ext;
	logic [4:0]         at_sat;
	logic [CW-1:0]      cat_a;
	link_t              head_a;
	logic               fp_found;
	logic [PW-1:0]      fp;
	logic [6:0]         fpage_ext;
	logic               f_page_ok;
	logic [PW-1:0]      f_page;
	logic [8:0]         fslot_ext;
	logic               f_slot_ok;
	logic [SW-1:0]      f_slot;
	logic [GW-1:0]      g_f;
	logic               f_ok;
	logic               dec_reject;
	logic               do_create;
	resp_t              res_rej;

	// pop, alloc and free completion
	logic [GW-1:0]      g_q;
	logic [CNT_W-1:0]   pop_c;
	logic [SW-1:0]      a_slot;
	logic [31:0]        a_bytes;
	logic [31:0]        a_count;
	logic [4:0]         fc_ext;
	logic [4:0]         fc_sat;
	logic [CW-1:0]      f_cat;
	logic [CNT_W-1:0]   fr_cnt;
	logic [CNT_W-1:0]   fr_new;
	logic               was_full;
	logic               retire;
	logic [31:0]        f_bytes;
	logic [31:0]        f_count;

	// list control
	logic               l_push;
	logic               l_remove;
	logic [CLASS_W-1:0] l_cls;
	logic [PW-1:0]      l_page;
	logic [GW-1:0]      l_g;
	link_t              l_head;
	link_t              l_pv;
	link_t              l_nx;

	always_comb begin
		is_free   = (req_q.req_type == REQ_FREE);
		cls_a     = class_of(req_q.size);
		too_large = cls_a[3];
		at_ext    = 5'(req_q.alloc_type);
		at_sat    = (at_ext >= 5'(CATEGORY_COUNT)) ? 5'(CATEGORY_COUNT - 1) : at_ext;
		cat_a     = at_sat[CW-1:0];
		head_a    = head_q[cls_a[CLASS_W-1:0]];
		fp_found  = 1'b0;
		fp        = '0;
		for (int i = PAGES_PER_CLASS - 1; i >= 0; i--) begin
			if (!active_q[{cls_a[CLASS_W-1:0], PW'(i)}]) begin
				fp_found = 1'b1;
				fp       = PW'(i);
			end
		end
		fpage_ext = 7'(req_q.free_page);
		f_page_ok = fpage_ext < 7'(PAGES_PER_CLASS);
		f_page    = fpage_ext[PW-1:0];
		fslot_ext = 9'(req_q.free_slot);
		f_slot_ok = fslot_ext < 9'(MAX_SLOTS_PER_PAGE);
		f_slot    = fslot_ext[SW-1:0];
		g_f       = {req_q.free_class, f_page};
		f_ok      = f_page_ok && f_slot_ok && active_q[g_f] && (cnt_q[g_f] < MAX_CNT);
		dec_reject = is_free ? !f_ok : (too_large || (!head_a.valid && !fp_found));
		do_create  = (cmd.op == OP_DECODE) && !is_free && !dec_reject && !head_a.valid;

		res_rej = '0;
		if (is_free) begin
			res_rej.status     = ST_NO_PAGE;
			res_rej.size_class = req_q.free_class;
			res_rej.page_index = req_q.free_page;
			res_rej.slot_index = req_q.free_slot;
		end else begin
			res_rej.status     = too_large ? ST_TOO_LARGE : ST_NO_PAGE;
			res_rej.size_class = too_large ? '0 : cls_a[CLASS_W-1:0];
			res_rej.type_bytes = bytes_q[cat_a];
			res_rej.type_count = count_q[cat_a];
		end
	end

	always_comb begin
		g_q     = {cls_q, page_q};
		pop_c   = cnt_q[g_q] - 1'b1;
		a_slot  = ident_q ? c_q[SW-1:0] : stack_rd_q;
		a_bytes = bytes_q[cat_q] + 32'(req_q.size);
		a_count = count_q[cat_q] + 32'd1;
		fc_ext  = 5'(info_rd_q.cat);
		fc_sat  = (fc_ext >= 5'(CATEGORY_COUNT)) ? 5'(CATEGORY_COUNT - 1) : fc_ext;
		f_cat   = fc_sat[CW-1:0];
		fr_cnt  = cnt_q[g_q];
		fr_new  = fr_cnt + 1'b1;
		was_full = (fr_cnt == '0);
		retire   = (fr_new == MAX_CNT);
		f_bytes  = bytes_q[f_cat] - 32'(info_rd_q.size);
		f_count  = count_q[f_cat] - 32'd1;
	end

	// one list operation a cycle: a push on page creation or refill, a removal on fill or retire
	always_comb begin
		l_push   = do_create || ((cmd.op == OP_FREE_DONE) && was_full);
		l_remove = ((cmd.op == OP_POP) && (pop_c == '0)) || ((cmd.op == OP_FREE_DONE) && retire);
		l_cls    = (cmd.op == OP_DECODE) ? cls_a[CLASS_W-1:0] : cls_q;
		l_page   = (cmd.op == OP_DECODE) ? fp : page_q;
		l_g      = {l_cls, l_page};
		l_head   = head_q[l_cls];
		l_pv     = prev_q[l_g];
		l_nx     = next_q[l_g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAGE_SLOTS; i++) begin
				active_q[i] <= 1'b0;
			end
			for (int i = 0; i < CLASS_COUNT; i++) begin
				head_q[i] <= '0;
			end
			for (int i = 0; i < CATEGORY_COUNT; i++) begin
				bytes_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (do_create) begin
				active_q[l_g] <= 1'b1;
			end
			if ((cmd.op == OP_FREE_DONE) && retire) begin
				active_q[g_q] <= 1'b0;
			end
			if (l_push) begin
				head_q[l_cls] <= '{valid: 1'b1, idx: l_page};
			end
			if (l_remove && l_head.valid && (l_head.idx == l_page)) begin
				head_q[l_cls] <= l_nx;
			end
			if (cmd.op == OP_ALLOC_DONE) begin
				bytes_q[cat_q] <= a_bytes;
				count_q[cat_q] <= a_count;
			end
			if (cmd.op == OP_FREE_DONE) begin
				bytes_q[f_cat] <= f_bytes;
				count_q[f_cat] <= f_count;
			end
		end
	end

	// link tables and per page counters, written before use
	always_ff @(posedge clk) begin
		if (l_push) begin
			prev_q[l_g] <= '0;
			next_q[l_g] <= l_head;
			if (l_head.valid) begin
				prev_q[{l_cls, l_head.idx}] <= '{valid: 1'b1, idx: l_page};
			end
		end
		if (l_remove) begin
			if (l_pv.valid) begin
				next_q[{l_cls, l_pv.idx}] <= l_nx;
			end
			if (l_nx.valid) begin
				prev_q[{l_cls, l_nx.idx}] <= l_pv;
			end
			prev_q[l_g].valid <= 1'b0;
			next_q[l_g].valid <= 1'b0;
		end
		if (do_create) begin
			cnt_q[l_g] <= MAX_CNT;
			low_q[l_g] <= MAX_CNT;
		end
		if (cmd.op == OP_POP) begin
			cnt_q[g_q] <= pop_c;
			if (pop_c < low_q[g_q]) begin
				low_q[g_q] <= pop_c;
			end
		end
		if (cmd.op == OP_FREE_DONE) begin
			cnt_q[g_q] <= fr_new;
		end
	end

	// request and step registers
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			req_q <= req;
		end
		if (cmd.op == OP_DECODE) begin
			cls_q  <= is_free ? req_q.free_class : cls_a[CLASS_W-1:0];
			page_q <= is_free ? f_page : (head_a.valid ? head_a.idx : fp);
			slot_q <= f_slot;
			cat_q  <= cat_a;
			res_q  <= res_rej;
		end
		if (cmd.op == OP_POP) begin
			c_q     <= pop_c;
			ident_q <= pop_c < low_q[g_q];
		end
		unique case (cmd.op)
			OP_ALLOC_DONE: begin
				rsp_q.status     <= ST_OK;
				rsp_q.size_class <= cls_q;
				rsp_q.page_index <= 2'(page_q);
				rsp_q.slot_index <= 8'(a_slot);
				rsp_q.type_bytes <= a_bytes;
				rsp_q.type_count <= a_count;
			end
			OP_FREE_DONE: begin
				rsp_q.status     <= ST_OK;
				rsp_q.size_class <= cls_q;
				rsp_q.page_index <= req_q.free_page;
				rsp_q.slot_index <= req_q.free_slot;
				rsp_q.type_bytes <= f_bytes;
				rsp_q.type_count <= f_count;
			end
			OP_REJECT_DONE: begin
				rsp_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (cmd.op == OP_POP) begin
			stack_rd_q <= stack_mem[{g_q, pop_c[SW-1:0]}];
		end
		if (cmd.op == OP_FREE_DONE) begin
			stack_mem[{g_q, fr_cnt[SW-1:0]}] <= slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.op == OP_DECODE) && is_free) begin
			info_rd_q <= info_mem[{g_f, f_slot}];
		end
		if (cmd.op == OP_ALLOC_DONE) begin
			info_mem[{g_q, a_slot}] <= '{size: req_q.size[SIZE_W-1:0], cat: req_q.alloc_type};
		end
	end

	assign sts.is_free = is_free;
	assign sts.reject  = dec_reject;
	assign rsp         = rsp_q;

`ifndef ASSERT_OFF
	a_pop_from_open_page: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_POP) |-> (head_q[cls_q].valid && active_q[g_q] && (cnt_q[g_q] != '0)))
		else $error("pop from a page that is not open");

	a_alloc_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_DECODE) && !is_free && !dec_reject) |=> head_q[cls_q].valid)
		else $error("accepted allocation left its class without an open page");

	a_push_remove_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(l_push && l_remove))
		else $error("open list push and removal in the same cycle");
`endif

endmodule

>>> rtl/core/scsa_ctrl.sv
// ----------------------------------------------------------------------------
// scsa_ctrl
// request sequencer of the slab allocator
// ----------------------------------------------------------------------------
module scsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  scsa_pkg::dp_status_t sts,
	output scsa_pkg::dp_cmd_t    cmd
);
	import scsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_ALLOC_WR,
		S_FREE_WR,
		S_REJECT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;
	logic   load;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.op  = OP_NONE;
		state_d = state_q;
		load    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.op = OP_DECODE;
				if (sts.reject) begin
					state_d = S_REJECT;
				end else if (sts.is_free) begin
					state_d = S_FREE_WR;
				end else begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.op  = OP_POP;
				state_d = S_ALLOC_WR;
			end
			S_ALLOC_WR: begin
				if (out_free) begin
					cmd.op  = OP_ALLOC_DONE;
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FREE_WR: begin
				if (out_free) begin
					cmd.op  = OP_FREE_DONE;
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_REJECT: begin
				if (out_free) begin
					cmd.op  = OP_REJECT_DONE;
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_DECODE))
		else $error("accepted beat not decoded next");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !load)
		else $error("result overwritten while stalled");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (rsp_valid_q && (state_q == S_IDLE)))
		else $error("finished result not presented");
`endif

endmodule
